// File: src/rca_pkg.sv
// Shared types and constants for the row cellular automaton core.
// No dependencies; imported by every module of the block except rca_ram.
`default_nettype none
package rca_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int TABLE_DEPTH = 512;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WIDTH_W = COL_W + 1;
    localparam int TAB_AW  = $clog2(TABLE_DEPTH);
    localparam int CELL_W  = 8;
    localparam int SUM_W   = CELL_W + 2;
    localparam int CFG_W   = 9;
    localparam int CFG_IW  = 1;

    localparam logic CMD_TABLE = 1'b0;
    localparam logic CMD_CELL  = 1'b1;

    localparam logic [CFG_IW-1:0] REG_ROW_WIDTH = 1'b0;
    localparam logic [CFG_IW-1:0] REG_TABLE_TOP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHIFT,
        ST_LOOK,
        ST_OUT
    } rca_state_t;

    typedef struct packed {
        logic take;
        logic shift;
        logic col_next;
    } rca_cmd_t;

    typedef struct packed {
        logic row_full;
        logic win_full;
        logic last_col;
    } rca_status_t;

endpackage
`default_nettype wire

// File: src/rca_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module rca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: src/rca_ctrl.sv
// Controller state machine: sequences cell intake and per-column emission.
// Depends on rca_pkg.
`default_nettype none
module rca_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire rca_pkg::rca_status_t status,
    output rca_pkg::rca_cmd_t         cmd
);
    import rca_pkg::*;

    rca_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && status.row_full) state_next = ST_FETCH;
            end
            ST_FETCH: state_next = ST_SHIFT;
            ST_SHIFT: begin
                state_next = status.win_full ? ST_LOOK : ST_FETCH;
            end
            ST_LOOK: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) state_next = status.last_col ? ST_IDLE : ST_FETCH;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        cmd.take     = 1'b0;
        cmd.shift    = 1'b0;
        cmd.col_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_FETCH: ;
            ST_SHIFT: cmd.shift = 1'b1;
            ST_LOOK:  ;
            ST_OUT: begin
                m_valid      = 1'b1;
                cmd.col_next = m_ready;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: src/rca_datapath.sv
// Datapath: config registers, line store, rule table, neighbor window and sum clamp.
// Depends on rca_pkg and rca_ram.
`default_nettype none
module rca_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [rca_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [rca_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_cmd,
    input  wire logic [rca_pkg::TAB_AW-1:0]    s_table_addr,
    input  wire logic [rca_pkg::CELL_W-1:0]    s_value,
    output logic      [rca_pkg::COL_W-1:0]     m_column,
    output logic      [rca_pkg::CELL_W-1:0]    m_cell_out,
    output logic                               m_row_end,
    input  wire rca_pkg::rca_cmd_t             cmd,
    output rca_pkg::rca_status_t               status
);
    import rca_pkg::*;

    logic [WIDTH_W-1:0] row_width_reg;
    logic [TAB_AW-1:0]  table_top_reg;
    logic [COL_W-1:0]   fill_reg, fill_next;
    logic [COL_W-1:0]   rd_ptr_reg;
    logic [COL_W-1:0]   col_reg;
    logic [1:0]         win_cnt_reg;
    logic [CELL_W-1:0]  win_l_reg, win_c_reg, win_r_reg;

    logic [WIDTH_W-1:0] eff_w, eff_w_m1;
    logic [TAB_AW-1:0]  eff_top;
    logic [SUM_W-1:0]   sum;
    logic [TAB_AW-1:0]  tab_raddr;
    logic [CELL_W-1:0]  line_rdata;
    logic               line_we, tab_we;

    always_comb begin
        eff_w = row_width_reg;
        if (row_width_reg < WIDTH_W'(2)) eff_w = WIDTH_W'(2);
        if (row_width_reg > WIDTH_W'(MAX_WIDTH)) eff_w = WIDTH_W'(MAX_WIDTH);
        eff_w_m1 = eff_w - WIDTH_W'(1);
        eff_top = table_top_reg;
        if ({1'b0, table_top_reg} > (TAB_AW + 1)'(TABLE_DEPTH - 1)) begin
            eff_top = TAB_AW'(TABLE_DEPTH - 1);
        end
    end

    assign status.row_full = (s_cmd == CMD_CELL)
                             && (({1'b0, fill_reg} + WIDTH_W'(1)) >= eff_w);
    assign status.win_full = win_cnt_reg[1];
    assign status.last_col = ({1'b0, col_reg} == eff_w_m1);

    assign fill_next = status.row_full ? '0 : fill_reg + COL_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= WIDTH_W'(MAX_WIDTH);
            table_top_reg <= TAB_AW'(TABLE_DEPTH - 1);
            fill_reg      <= '0;
            win_cnt_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_ROW_WIDTH: row_width_reg <= cfg_wdata[WIDTH_W-1:0];
                    REG_TABLE_TOP: table_top_reg <= cfg_wdata[TAB_AW-1:0];
                    default: ;
                endcase
            end
            if (cmd.take && s_cmd == CMD_CELL) begin
                fill_reg <= fill_next;
                if (status.row_full) win_cnt_reg <= '0;
            end
            if (cmd.shift && win_cnt_reg != 2'd3) win_cnt_reg <= win_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && status.row_full) begin
            rd_ptr_reg <= eff_w_m1[COL_W-1:0];
            col_reg    <= '0;
        end
        if (cmd.shift) begin
            win_l_reg  <= win_c_reg;
            win_c_reg  <= win_r_reg;
            win_r_reg  <= line_rdata;
            rd_ptr_reg <= ({1'b0, rd_ptr_reg} == eff_w_m1) ? '0 : rd_ptr_reg + COL_W'(1);
        end
        if (cmd.col_next) col_reg <= col_reg + COL_W'(1);
    end

    always_comb begin
        sum = SUM_W'(win_l_reg) + SUM_W'(win_c_reg) + SUM_W'(win_r_reg);
        tab_raddr = (sum > SUM_W'(eff_top)) ? eff_top : sum[TAB_AW-1:0];
    end

    assign line_we = cmd.take && (s_cmd == CMD_CELL);
    assign tab_we  = cmd.take && (s_cmd == CMD_TABLE)
                     && ({1'b0, s_table_addr} < (TAB_AW + 1)'(TABLE_DEPTH));

    rca_ram #(.WIDTH(CELL_W), .DEPTH(MAX_WIDTH)) u_line_store (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (fill_reg),
        .wdata (s_value),
        .raddr (rd_ptr_reg),
        .rdata (line_rdata)
    );

    rca_ram #(.WIDTH(CELL_W), .DEPTH(TABLE_DEPTH)) u_rule_table (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (s_table_addr),
        .wdata (s_value),
        .raddr (tab_raddr),
        .rdata (m_cell_out)
    );

    assign m_column  = col_reg;
    assign m_row_end = status.last_col;

endmodule
`default_nettype wire

// File: src/row_cellular_automaton_core.sv
// Row cellular automaton core: one item at a time. A table write or a non-final
// cell is taken while idle and leaves the core ready for the next item. The final
// cell of a row starts emission; the first result comes after three fetch/shift pairs
// and a lookup, and each further column passes through line-store fetch, window
// shift, rule-table lookup and output, which holds while the output is stalled.
// Synchronous active-low reset: row_width 64, table_top 511, fill column 0;
// line store and rule table contents are undefined until written.
`default_nettype none
module row_cellular_automaton_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [rca_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [rca_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [rca_pkg::TAB_AW-1:0]    s_table_addr,
    input  wire logic [rca_pkg::CELL_W-1:0]    s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [rca_pkg::COL_W-1:0]     m_column,
    output logic      [rca_pkg::CELL_W-1:0]    m_cell_out,
    output logic                               m_row_end
);
    import rca_pkg::*;

    rca_cmd_t    cmd;
    rca_status_t status;

    rca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rca_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_cmd        (s_cmd),
        .s_table_addr (s_table_addr),
        .s_value      (s_value),
        .m_column     (m_column),
        .m_cell_out   (m_cell_out),
        .m_row_end    (m_row_end),
        .cmd          (cmd),
        .status       (status)
    );

`ifndef SYNTHESIS
    a_no_intake_while_emitting: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready during emission");

    a_idle_after_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_row_end |=> s_ready) else $error("no return to idle");

    a_row_starts_emission: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && status.row_full |=> !s_ready)
        else $error("final cell did not start emission");

    a_column_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_row_end |=> !m_valid) else $error("column transfer overlap");
`endif

endmodule
`default_nettype wire

// File: dv/rca_result_checker.sv
`timescale 1ns / 100ps
// Scoreboard for row_cellular_automaton_core: tracks config writes and input
// transfers, computes each new row and compares it with the result channel.
// Depends on rca_pkg for widths, commands and register indexes.
module rca_result_checker
    import rca_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IW-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic                 s_cmd,
    input  wire logic [TAB_AW-1:0]    s_table_addr,
    input  wire logic [CELL_W-1:0]    s_value,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [COL_W-1:0]     m_column,
    input  wire logic [CELL_W-1:0]    m_cell_out,
    input  wire logic                 m_row_end,
    output int                        mismatches,
    output int                        cells_pending
);

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [CELL_W-1:0] cell_val;
        logic              row_end;
    } new_cell_t;

    new_cell_t          next_row_q[$];
    logic [CELL_W-1:0]  rule_words [TABLE_DEPTH];
    logic [CELL_W-1:0]  row_cells [MAX_WIDTH];
    int                 fill_col;
    logic [WIDTH_W-1:0] width_reg;
    logic [CFG_W-1:0]   top_reg;

    function automatic void check_field(input string field, input logic [CELL_W-1:0] want,
                                        input logic [CELL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    task automatic evolve_row(input int w);
        int        top;
        int        left;
        int        right;
        int        sum;
        new_cell_t nc;
        top = (int'(top_reg) > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : int'(top_reg);
        for (int c = 0; c < w; c++) begin
            left  = (c == 0) ? w - 1 : c - 1;
            right = (c == w - 1) ? 0 : c + 1;
            sum   = row_cells[left] + row_cells[c] + row_cells[right];
            if (sum > top) sum = top;
            nc.column   = COL_W'(c);
            nc.cell_val = rule_words[sum];
            nc.row_end  = (c == w - 1);
            next_row_q.push_back(nc);
        end
    endtask

    task automatic apply_transfer(input logic cmd, input logic [TAB_AW-1:0] addr,
                                  input logic [CELL_W-1:0] val);
        int w;
        if (cmd == CMD_TABLE) begin
            if (addr < TABLE_DEPTH) rule_words[addr] = val;
        end else begin
            w = int'(width_reg);
            if (w < 2) w = 2;
            else if (w > MAX_WIDTH) w = MAX_WIDTH;
            row_cells[fill_col] = val;
            if (fill_col + 1 < w) begin
                fill_col++;
            end else begin
                fill_col = 0;
                evolve_row(w);
            end
        end
    endtask

    always @(posedge aclk) begin
        new_cell_t nc;
        if (!aresetn) begin
            next_row_q.delete();
            fill_col  = 0;
            width_reg = WIDTH_W'(MAX_WIDTH);
            top_reg   = CFG_W'(TABLE_DEPTH - 1);
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_ROW_WIDTH) width_reg = cfg_wdata[WIDTH_W-1:0];
                else if (cfg_index == REG_TABLE_TOP) top_reg = cfg_wdata[CFG_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (next_row_q.size() == 0) begin
                    $error("result with nothing pending: column %0d, cell_out %0d",
                           m_column, m_cell_out);
                    mismatches++;
                end else begin
                    nc = next_row_q.pop_front();
                    check_field("column", CELL_W'(nc.column), CELL_W'(m_column));
                    check_field("cell_out", nc.cell_val, m_cell_out);
                    check_field("row_end", CELL_W'(nc.row_end), CELL_W'(m_row_end));
                end
            end
            if (s_valid && s_ready) apply_transfer(s_cmd, s_table_addr, s_value);
        end
        cells_pending = next_row_q.size();
    end

endmodule

// File: dv/row_cellular_automaton_core_test.sv
`timescale 1ns / 100ps
// Top-level testbench for row_cellular_automaton_core: drives config writes,
// table and cell transfers with random idling, and reports the verdict.
// Depends on rca_pkg, the core and rca_result_checker.
module row_cellular_automaton_core_test;
    import rca_pkg::*;

    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 30;
    localparam int TABLE_FILL   = 16;
    localparam int ROW_EXTRA    = 4;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic                s_cmd;
    logic [TAB_AW-1:0]   s_table_addr;
    logic [CELL_W-1:0]   s_value;
    logic                m_valid;
    logic                m_ready;
    logic [COL_W-1:0]    m_column;
    logic [CELL_W-1:0]   m_cell_out;
    logic                m_row_end;
    int                  mismatches;
    int                  cells_pending;
    bit                  gaps_on;
    bit                  long_hold_req;
    int                  items_sent;

    row_cellular_automaton_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_table_addr (s_table_addr),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_column     (m_column),
        .m_cell_out   (m_cell_out),
        .m_row_end    (m_row_end)
    );

    rca_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_table_addr  (s_table_addr),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_column      (m_column),
        .m_cell_out    (m_cell_out),
        .m_row_end     (m_row_end),
        .mismatches    (mismatches),
        .cells_pending (cells_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random back-pressure bursts, plus one long hold on request
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_item(input logic cmd, input logic [TAB_AW-1:0] addr,
                             input logic [CELL_W-1:0] val);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_table_addr <= addr;
        s_value      <= val;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_cell(input logic [CELL_W-1:0] val);
        send_item(CMD_CELL, TAB_AW'($urandom_range(0, TABLE_DEPTH - 1)), val);
    endtask

    // stop sending and wait until every pending new cell has been checked
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (cells_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] width_data,
                                input logic [CFG_W-1:0] top);
        write_reg(REG_ROW_WIDTH, width_data);
        write_reg(REG_TABLE_TOP, top);
    endtask

    task automatic random_item();
        logic [CELL_W-1:0] val;
        logic [TAB_AW-1:0] addr;
        case ($urandom_range(0, 7))
            0:       val = '0;
            1:       val = '1;
            2:       val = CELL_W'($urandom_range(0, 255));
            default: val = CELL_W'($urandom_range(0, 7));
        endcase
        if ($urandom_range(0, 1) == 0)
            addr = TAB_AW'($urandom_range(0, TABLE_FILL - 1));
        else
            addr = TAB_AW'($urandom_range(0, TABLE_DEPTH - 1));
        if ($urandom_range(0, 7) == 0)
            send_item(CMD_TABLE, addr, val);
        else
            send_cell(val);
    endtask

    initial begin
        int w;
        int eff_w;
        int n;
        logic [CFG_W-1:0] top;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ROW_WIDTH;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_cmd         = CMD_CELL;
        s_table_addr  = '0;
        s_value       = '0;
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;
        items_sent    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // low rule table words; table_top and cell values keep lookups below TABLE_FILL
        for (int a = 0; a < TABLE_FILL; a++)
            send_item(CMD_TABLE, TAB_AW'(a), CELL_W'($urandom_range(0, 255)));

        // directed
        send_item(CMD_TABLE, '0, '0);
        send_item(CMD_TABLE, '1, '1);
        settle();
        set_geometry(9'd2, CFG_W'(TABLE_FILL - 1));
        send_cell(8'd255);
        send_cell(8'd255);
        send_cell(8'd0);
        send_cell(8'd0);
        settle();
        set_geometry(9'd3, 9'd0);
        send_cell(8'd1);
        send_cell(8'd2);
        send_cell(8'd3);
        settle();
        set_geometry(9'd5, 9'd511);
        send_cell(8'd1);
        send_cell(8'd0);
        send_cell(8'd5);
        send_cell(8'd7);
        send_cell(8'd2);
        settle();
        // shrink the width with a row partly filled: next cell closes the row
        set_geometry(9'd10, CFG_W'(TABLE_FILL - 1));
        repeat (6) send_cell(CELL_W'($urandom_range(0, 255)));
        settle();
        write_reg(REG_ROW_WIDTH, 9'd4);
        send_cell(8'd99);
        settle();
        write_reg(REG_ROW_WIDTH, 9'd1);
        send_cell(8'd17);
        send_cell(8'd240);
        settle();

        // full-width row with a long output stall while the input keeps coming
        set_geometry(9'd127, CFG_W'(TABLE_FILL - 1));
        for (int i = 0; i < MAX_WIDTH + ROW_EXTRA; i++) begin
            if (i == MAX_WIDTH - 1) long_hold_req = 1'b1;
            send_cell(CELL_W'($urandom_range(0, 255)));
        end
        settle();

        // random phases
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent > RANDOM_ITEMS * 3 / 4) gaps_on = 1'b0;
            case ($urandom_range(0, 19))
                0, 1:    w = $urandom_range(0, 1);
                2:       w = $urandom_range(MAX_WIDTH + 1, 127);
                3, 4, 5: w = $urandom_range(10, 20);
                default: w = $urandom_range(2, 9);
            endcase
            case ($urandom_range(0, 5))
                0:       top = '0;
                1:       top = CFG_W'(TABLE_FILL - 1);
                default: top = CFG_W'($urandom_range(0, TABLE_FILL - 1));
            endcase
            eff_w = (w < 2) ? 2 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
            n = $urandom_range(1, 2) * eff_w + $urandom_range(0, 2);
            if (n > RANDOM_ITEMS - items_sent + 2) n = RANDOM_ITEMS - items_sent + 2;
            settle();
            set_geometry({2'($urandom_range(0, 3)), 7'(w)}, top);
            repeat (n) random_item();
        end
        settle();

        if (mismatches == 0 && cells_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/rca_pkg.sv
src/rca_ram.sv
src/rca_ctrl.sv
src/rca_datapath.sv
src/row_cellular_automaton_core.sv
dv/rca_result_checker.sv
dv/row_cellular_automaton_core_test.sv
